@@ sv/bra_pkg.sv @@
// Package for the bitmap run allocator: sizes, command codes, payload and control types.
package bra_pkg;

   localparam int MAX_BITS  = 4096;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
   localparam int ADDR_W    = $clog2(NUM_WORDS);
   localparam int OFF_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(WORD_BITS + 1);

   typedef enum logic [2:0] {
      MODE_SET     = 3'd0,
      MODE_CHECK   = 3'd1,
      MODE_FIND    = 3'd2,
      MODE_ALLOC   = 3'd3,
      MODE_LONGEST = 3'd4,
      MODE_COUNT   = 3'd5,
      MODE_RSVD6   = 3'd6,
      MODE_RSVD7   = 3'd7
   } mode_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        bit_value;
      logic [11:0] position;
      logic [12:0] run_length;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] start_bit;
      logic [12:0] bit_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DECODE,
      ST_RD,
      ST_WAIT,
      ST_BIT,
      ST_WR,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_BIT,
      ST_FIN,
      ST_RESP
   } state_type;

   // Command from controller to datapath.
   typedef struct packed {
      logic load;       // capture request and effective size
      logic clr_wr;     // write zero at clear counter
      logic clr_inc;
      logic rd_bit;     // issue read of word holding cursor bit
      logic bit_step;   // process one bit from read data
      logic wr_word;    // write back modified word
      logic fin;        // fix up result
      logic restart;    // restart find from zero
   } ctl_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clr_done;
      logic invalid;    // command finishes immediately
      logic scan_done;  // cursor at its last bit, run found or check mismatch
      logic word_end;   // cursor at last bit of word or end
      logic need_wr;    // modified word must be written back
      logic retry;      // find must wrap around
      logic alloc_go;   // find succeeded and must invert
   } sts_type;

endpackage

@@ sv/bra_ram.sv @@
// Generic single-port RAM with registered read.
module bra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

@@ sv/bra_ctrl.sv @@
// Controller state machine of the bitmap run allocator.
module bra_ctrl import bra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output logic    rsp_strobe,
   output ctl_type ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_DECODE;
         ST_CLEAR:  if (sts.clr_done) state_in = ST_IDLE;
         ST_DECODE: begin
            if (sts.invalid) state_in = ST_RESP;
            else state_in = ST_RD;
         end
         ST_RD:     state_in = ST_WAIT;
         ST_WAIT:   state_in = ST_BIT;
         ST_BIT: begin
            priority if (sts.scan_done || sts.word_end) begin
               state_in = sts.need_wr ? ST_WR : (sts.scan_done ? ST_FIN : ST_RD);
            end else begin
               state_in = ST_BIT;
            end
         end
         ST_WR:     state_in = sts.scan_done ? ST_FIN : ST_RD;
         ST_FIN: begin
            priority if (sts.retry || sts.alloc_go) state_in = ST_RD;
            else state_in = ST_RESP;
         end
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin
            busy     = 1'b0;
            ctl.load = start;
         end
         ST_CLEAR: begin
            ctl.clr_wr  = 1'b1;
            ctl.clr_inc = 1'b1;
         end
         ST_RD:    ctl.rd_bit = 1'b1;
         ST_BIT:   ctl.bit_step = 1'b1;
         ST_WR:    ctl.wr_word = 1'b1;
         ST_FIN:   begin
            ctl.fin     = 1'b1;
            ctl.restart = sts.retry;
         end
         ST_RESP:  rsp_strobe = 1'b1;
         default:  ctl = '0;
      endcase
   end
endmodule

@@ sv/bra_dp.sv @@
// Datapath of the bitmap run allocator: bit store, cursor, run counters and result.
module bra_dp import bra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  req_type     req,
   input  logic [12:0] size_bits,
   output sts_type     sts,
   output rsp_type     rsp
);
   logic [ADDR_W:0]    clr_ff;
   req_type            cmd_ff;
   logic [12:0]        cur_ff, end_ff, run_ff, best_ff, cnt_ff, need_ff;
   logic [11:0]        run_at_ff, best_at_ff, hint_ff;
   logic               ok_ff, found_ff, wval_ff, wpass_ff, wrapped_ff;
   logic [WORD_BITS-1:0] word_ff, rd_data, ram_wdata;
   logic [ADDR_W-1:0]  ram_addr;
   logic               ram_we, first_ff;
   logic [12:0]        set_room, set_len, hint_eff, pos_ext, sz_eff;
   logic               cur_bit, match, wend, sdone;
   logic [12:0]        run_nx, cnt_nx;
   mode_type           md;
   logic [WORD_BITS-1:0] w_cur, w_mod;
   logic               inv_ff;

   assign md       = mode_type'(cmd_ff.mode);
   assign sz_eff   = (size_bits > 13'(MAX_BITS)) ? 13'(MAX_BITS) : size_bits;
   assign pos_ext  = {1'b0, req.position};
   assign set_room = sz_eff - pos_ext;
   assign set_len  = (req.run_length > set_room) ? set_room : req.run_length;
   assign hint_eff = (pos_ext >= sz_eff) ? 13'd0 : pos_ext;

   assign ram_we    = ctl.clr_wr || ctl.wr_word;
   assign ram_addr  = ctl.clr_wr ? clr_ff[ADDR_W-1:0] : cur_ff[OFF_W +: ADDR_W];
   assign ram_wdata = ctl.clr_wr ? '0 : word_ff;

   bra_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(rd_data)
   );

   // The word is taken from the RAM on the first bit step after a read.
   assign w_cur   = first_ff ? rd_data : word_ff;
   assign cur_bit = w_cur[cur_ff[OFF_W-1:0]];
   assign match   = (cur_bit == cmd_ff.bit_value);
   assign run_nx  = match ? run_ff + 13'd1 : 13'd0;
   assign cnt_nx  = cnt_ff + {12'd0, match};
   assign wend    = (cur_ff[OFF_W-1:0] == OFF_W'(WORD_BITS - 1)) || (cur_ff + 13'd1 >= end_ff);

   always_comb begin
      w_mod = w_cur;
      w_mod[cur_ff[OFF_W-1:0]] = wval_ff;
   end

   // Scan is over after this bit when the end is reached, a needed run completes or a check finds a mismatch.
   always_comb begin
      sdone = (cur_ff + 13'd1 >= end_ff);
      if ((md == MODE_FIND || md == MODE_ALLOC) && !wpass_ff && run_nx >= need_ff) sdone = 1'b1;
      if (md == MODE_CHECK && !match) sdone = 1'b1;
   end

   assign sts.clr_done  = (clr_ff == (ADDR_W+1)'(NUM_WORDS - 1));
   assign sts.word_end  = wend;
   assign sts.scan_done = sdone;
   assign sts.need_wr   = wpass_ff;
   assign sts.retry     = !wpass_ff && (md == MODE_FIND || md == MODE_ALLOC) && !found_ff
                          && !wrapped_ff && hint_ff != 12'd0;
   assign sts.alloc_go  = !wpass_ff && md == MODE_ALLOC && found_ff && need_ff != 13'd0;
   assign sts.invalid   = inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clr_inc && !sts.clr_done) begin
         clr_ff <= clr_ff + (ADDR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= ctl.rd_bit ? 1'b1 : (ctl.bit_step ? 1'b0 : first_ff);
      if (ctl.load) begin
         cmd_ff     <= req;
         run_ff     <= '0;
         run_at_ff  <= '0;
         best_ff    <= '0;
         best_at_ff <= '0;
         cnt_ff     <= '0;
         ok_ff      <= 1'b0;
         found_ff   <= 1'b0;
         wpass_ff   <= 1'b0;
         wrapped_ff <= 1'b0;
         need_ff    <= req.run_length;
         wval_ff    <= req.bit_value;
         inv_ff     <= 1'b1;
         hint_ff    <= '0;
         cur_ff     <= '0;
         end_ff     <= sz_eff;
         unique case (mode_type'(req.mode))
            MODE_SET: begin
               if (req.run_length != 13'd0 && pos_ext < sz_eff) begin
                  inv_ff   <= 1'b0;
                  wpass_ff <= 1'b1;
                  ok_ff    <= 1'b1;
                  cur_ff   <= pos_ext;
                  cnt_ff   <= set_len;
                  end_ff   <= pos_ext + set_len;
               end
            end
            MODE_CHECK: begin
               if (req.run_length != 13'd0 && {1'b0, pos_ext} + {1'b0, req.run_length}
                   <= {1'b0, sz_eff}) begin
                  inv_ff <= 1'b0;
                  ok_ff  <= 1'b1;
                  cur_ff <= pos_ext;
                  end_ff <= pos_ext + req.run_length;
               end
            end
            MODE_FIND, MODE_ALLOC: begin
               if (req.run_length <= sz_eff) begin
                  best_at_ff <= hint_eff[11:0];
                  if (req.run_length == 13'd0) begin
                     ok_ff <= 1'b1;
                  end else begin
                     inv_ff  <= 1'b0;
                     hint_ff <= hint_eff[11:0];
                     cur_ff  <= hint_eff;
                  end
               end
            end
            MODE_LONGEST: inv_ff <= (sz_eff == 13'd0);
            MODE_COUNT: begin
               ok_ff  <= 1'b1;
               inv_ff <= (sz_eff == 13'd0);
            end
            default: inv_ff <= 1'b1;
         endcase
      end else if (ctl.bit_step) begin
         if (wpass_ff) begin
            word_ff <= w_mod;
         end else begin
            word_ff <= w_cur;
            run_ff  <= run_nx;
            if (match && run_ff == 13'd0) run_at_ff <= cur_ff[11:0];
            unique case (md)
               MODE_CHECK: if (!match) ok_ff <= 1'b0;
               MODE_LONGEST: begin
                  if (run_nx > best_ff) begin
                     best_ff    <= run_nx;
                     best_at_ff <= (run_ff == 13'd0) ? cur_ff[11:0] : run_at_ff;
                  end
               end
               MODE_COUNT: cnt_ff <= cnt_nx;
               MODE_FIND, MODE_ALLOC: begin
                  if (run_nx >= need_ff) begin
                     found_ff   <= 1'b1;
                     best_at_ff <= 12'(cur_ff + 13'd1 - need_ff);
                  end
               end
               default: ;
            endcase
         end
         // A modified word is written back at the cursor before it moves on.
         if (!sdone && !(wpass_ff && wend)) cur_ff <= cur_ff + 13'd1;
      end else if (ctl.wr_word) begin
         if (!sdone) cur_ff <= cur_ff + 13'd1;
      end else if (ctl.fin) begin
         if (ctl.restart) begin
            wrapped_ff <= 1'b1;
            cur_ff     <= '0;
            run_ff     <= '0;
         end else if (sts.alloc_go) begin
            ok_ff    <= 1'b1;
            wpass_ff <= 1'b1;
            wval_ff  <= ~cmd_ff.bit_value;
            cur_ff   <= {1'b0, best_at_ff};
            end_ff   <= {1'b0, best_at_ff} + need_ff;
         end else if (!wpass_ff) begin
            unique case (md)
               MODE_FIND, MODE_ALLOC: begin
                  ok_ff <= found_ff;
                  if (!found_ff) best_at_ff <= '0;
               end
               MODE_LONGEST: begin
                  ok_ff  <= (best_ff != 13'd0);
                  cnt_ff <= best_ff;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp.ok        = ok_ff;
      rsp.start_bit = '0;
      rsp.bit_count = '0;
      unique case (md)
         MODE_SET:              rsp.bit_count = cnt_ff;
         MODE_FIND, MODE_ALLOC: rsp.start_bit = best_at_ff;
         MODE_LONGEST: begin
            rsp.start_bit = best_at_ff;
            rsp.bit_count = cnt_ff;
         end
         MODE_COUNT:            rsp.bit_count = cnt_ff;
         default: ;
      endcase
      if (md == MODE_LONGEST && !ok_ff) rsp.start_bit = '0;
   end
endmodule

@@ sv/bitmap_run_allocator_top.sv @@
// Top level of the bitmap run allocator: controller, datapath and register.
// A transaction that finishes at once goes from decode straight to its response strobe.
// Otherwise each word is read from the bit store, its bits are stepped through in turn and
// a modified word is written back before the cursor moves on; a find may wrap around once,
// an alloc inverts the run found. busy is high until after the strobe; the receiver cannot stall.
// After reset the bit store is cleared, all 128 words, with busy high; size_bits resets to 4096.
module bitmap_run_allocator_top import bra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   logic [12:0] size_ff;
   ctl_type     ctl;
   sts_type     sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 13'd4096;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   bra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .rsp_strobe(rsp_valid),
      .ctl       (ctl)
   );

   bra_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req      (req_data),
      .size_bits(size_ff),
      .sts      (sts),
      .rsp      (rsp_data)
   );
endmodule

@@ dv/bitmap_run_allocator_top_test.sv @@
// Self-checking testbench for the bitmap run allocator: directed and random commands.
module bitmap_run_allocator_top_test import bra_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   class bitmap_scoreboard;
      bit      bitmap[MAX_BITS];
      int      size_reg = 4096;
      rsp_type expected_rsps[$];
      int      errors = 0;
      int      checked = 0;

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int run_from(int from, int sz, int len, bit v);
         int cnt;
         cnt = 0;
         for (int i = from; i < sz; i++) begin
            if (bitmap[i] == v) begin
               cnt++;
               if (cnt >= len) return i + 1 - len;
            end else begin
               cnt = 0;
            end
         end
         return -1;
      endfunction

      function rsp_type predict(req_type r);
         int sz, pos, len, s, best, best_at, cur, cur_at;
         bit v;
         rsp_type o;
         sz = size_reg > MAX_BITS ? MAX_BITS : size_reg;
         v = r.bit_value;
         pos = r.position;
         len = r.run_length;
         o = '0;
         case (mode_type'(r.mode))
            MODE_SET: begin
               if (len != 0 && pos < sz) begin
                  if (len > sz - pos) len = sz - pos;
                  for (int i = 0; i < len; i++) bitmap[pos + i] = v;
                  o.ok = 1'b1;
                  o.bit_count = 13'(len);
               end
            end
            MODE_CHECK: begin
               if (len != 0 && pos + len <= sz) begin
                  o.ok = 1'b1;
                  for (int i = 0; i < len; i++)
                     if (bitmap[pos + i] != v) o.ok = 1'b0;
               end
            end
            MODE_FIND, MODE_ALLOC: begin
               if (len <= sz) begin
                  if (pos >= sz) pos = 0;
                  if (len == 0) begin
                     s = pos;
                  end else begin
                     s = run_from(pos, sz, len, v);
                     if (s < 0 && pos != 0) s = run_from(0, sz, len, v);
                  end
                  if (s >= 0) begin
                     o.ok = 1'b1;
                     o.start_bit = 12'(s);
                     if (mode_type'(r.mode) == MODE_ALLOC)
                        for (int i = 0; i < len; i++) bitmap[s + i] = ~v;
                  end
               end
            end
            MODE_LONGEST: begin
               best = 0; best_at = 0; cur = 0; cur_at = 0;
               for (int i = 0; i < sz; i++) begin
                  if (bitmap[i] == v) begin
                     if (cur == 0) cur_at = i;
                     cur++;
                     if (cur > best) begin
                        best = cur;
                        best_at = cur_at;
                     end
                  end else begin
                     cur = 0;
                  end
               end
               if (best > 0) begin
                  o.ok = 1'b1;
                  o.start_bit = 12'(best_at);
                  o.bit_count = 13'(best);
               end
            end
            MODE_COUNT: begin
               o.ok = 1'b1;
               for (int i = 0; i < sz; i++)
                  if (bitmap[i] == v) o.bit_count++;
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         expected_rsps.push_back(predict(r));
      endfunction

      task check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_rsps.size() == 0) begin
            report("response with no transaction outstanding");
            return;
         end
         exp_rsp = expected_rsps.pop_front();
         checked++;
         if (got.ok !== exp_rsp.ok)
            report($sformatf("ok %b, expected %b", got.ok, exp_rsp.ok));
         if (got.start_bit !== exp_rsp.start_bit)
            report($sformatf("start_bit %0d, expected %0d", got.start_bit, exp_rsp.start_bit));
         if (got.bit_count !== exp_rsp.bit_count)
            report($sformatf("bit_count %0d, expected %0d", got.bit_count, exp_rsp.bit_count));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   bitmap_scoreboard sb = new();
   int sent = 0;

   bitmap_run_allocator_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

   task automatic send(input mode_type m, input bit v, input int pos, input int len,
                       input int idle_pct);
      req_type r;
      r.mode = m;
      r.bit_value = v;
      r.position = 12'(pos);
      r.run_length = 13'(len);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsps.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_size(input int value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= 13'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.size_reg = value;
   endtask

   task automatic random_item(input int sz, input int idle_pct);
      int m, pos, len, lim;
      m = $urandom_range(99);
      if (m < 3) m = $urandom_range(6, 7);
      else m = m % 6;
      lim = sz < 1 ? 1 : sz;
      pos = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(lim);
      case ($urandom_range(9))
         0: len = $urandom_range(8191);
         1: len = 0;
         2: len = lim;
         default: len = $urandom_range(1, lim / 4 + 2);
      endcase
      send(mode_type'(m), 1'($urandom_range(1)), pos, len, idle_pct);
   endtask

   initial begin
      int sizes[10];
      int counts[10];
      int idles[4];
      sizes = '{0, 1, 33, 100, 160, 8191, 64, 128, 4096, 97};
      counts = '{40, 60, 200, 200, 200, 15, 200, 200, 15, 100};
      idles = '{0, 69, 0, 36};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_COUNT, 1'b0, 0, 0, 0);
      send(MODE_SET, 1'b1, 0, 4096, 0);
      send(MODE_COUNT, 1'b1, 0, 0, 0);
      send(MODE_CHECK, 1'b1, 0, 4096, 0);
      send(MODE_LONGEST, 1'b1, 0, 0, 0);
      send(MODE_LONGEST, 1'b0, 0, 0, 0);
      send(MODE_FIND, 1'b1, 4095, 4096, 0);
      send(MODE_ALLOC, 1'b1, 0, 4096, 0);
      send(MODE_SET, 1'b1, 4095, 8191, 0);
      send(MODE_CHECK, 1'b1, 4095, 1, 0);
      send(MODE_CHECK, 1'b1, 4095, 2, 0);
      send(MODE_FIND, 1'b1, 4095, 1, 0);
      send(MODE_FIND, 1'b1, 100, 2, 0);
      send(MODE_FIND, 1'b0, 100, 0, 0);
      send(MODE_SET, 1'b1, 10, 0, 0);
      send(MODE_SET, 1'b1, 200, 5, 0);
      send(MODE_SET, 1'b1, 300, 5, 0);
      send(MODE_LONGEST, 1'b1, 0, 0, 0);
      send(MODE_ALLOC, 1'b0, 250, 50, 0);
      send(MODE_RSVD6, 1'b1, 4095, 8191, 0);
      send(MODE_RSVD7, 1'b0, 0, 0, 0);
      set_size(50);
      send(MODE_FIND, 1'b0, 4000, 3, 0);
      send(MODE_SET, 1'b1, 50, 3, 0);
      send(MODE_CHECK, 1'b0, 40, 11, 0);

      for (int p = 0; p < 10; p++) begin
         set_size(sizes[p]);
         for (int k = 0; k < counts[p]; k++)
            random_item(sizes[p] > MAX_BITS ? MAX_BITS : sizes[p], idles[(p + k / 50) % 4]);
      end
      wait_drained();

      $display("Ran %0d commands over ten bitmap sizes from 0 to 8191 with varied idling;",
               sent);
      $display("%0d responses compared, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected_rsps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
